@@ design/icx_pkg.sv @@
// Shared types, opcodes and constants of the integer execute unit.
package icx_pkg;

	localparam logic [5:0] OP_HLT  = 6'h00;
	localparam logic [5:0] OP_WAIT = 6'h01;
	localparam logic [5:0] OP_JMP  = 6'h02;
	localparam logic [5:0] OP_CALL = 6'h03;
	localparam logic [5:0] OP_RET  = 6'h04;
	localparam logic [5:0] OP_JT   = 6'h05;
	localparam logic [5:0] OP_JF   = 6'h06;
	localparam logic [5:0] OP_IEQ  = 6'h07;
	localparam logic [5:0] OP_INE  = 6'h08;
	localparam logic [5:0] OP_IGT  = 6'h09;
	localparam logic [5:0] OP_IGE  = 6'h0A;
	localparam logic [5:0] OP_ILT  = 6'h0B;
	localparam logic [5:0] OP_ILE  = 6'h0C;
	localparam logic [5:0] OP_MOV  = 6'h13;
	localparam logic [5:0] OP_PUSH = 6'h15;
	localparam logic [5:0] OP_POP  = 6'h16;
	localparam logic [5:0] OP_IN   = 6'h17;
	localparam logic [5:0] OP_CIB  = 6'h1E;
	localparam logic [5:0] OP_NOT  = 6'h20;
	localparam logic [5:0] OP_AND  = 6'h21;
	localparam logic [5:0] OP_OR   = 6'h22;
	localparam logic [5:0] OP_XOR  = 6'h23;
	localparam logic [5:0] OP_BNOT = 6'h24;
	localparam logic [5:0] OP_SHL  = 6'h25;
	localparam logic [5:0] OP_ADD  = 6'h26;
	localparam logic [5:0] OP_SUB  = 6'h27;
	localparam logic [5:0] OP_MUL  = 6'h28;
	localparam logic [5:0] OP_DIV  = 6'h29;
	localparam logic [5:0] OP_MOD  = 6'h2A;

	localparam logic [1:0] FAULT_NONE  = 2'd0;
	localparam logic [1:0] FAULT_DIV0  = 2'd1;
	localparam logic [1:0] FAULT_UNSUP = 2'd2;

	localparam logic [3:0] SP_INDEX = 4'd15;

	typedef struct packed {
		logic        start;
		logic        is_mod;
		logic [31:0] dividend;
		logic [31:0] divisor;
	} div_req_t;

	typedef struct packed {
		logic        done;
		logic [31:0] value;
	} div_rsp_t;

endpackage

@@ design/icx_divider.sv @@
// Iterative signed divider, one quotient bit per cycle.
module icx_divider
	import icx_pkg::*;
(
	input  logic     clk,
	input  logic     arst_n,
	input  div_req_t req,
	output div_rsp_t rsp
);

	logic        busy_q;
	logic [5:0]  cnt_q;
	logic [31:0] quo_q;
	logic [32:0] rem_q;
	logic [31:0] dvs_q;
	logic        negq_q;
	logic        negr_q;
	logic        mod_q;
	logic        done_q;
	logic [32:0] trial;
	logic [32:0] shifted;
	logic [31:0] adiv;
	logic [31:0] ados;

	assign adiv = req.dividend[31] ? 32'(-req.dividend) : req.dividend;
	assign ados = req.divisor[31] ? 32'(-req.divisor) : req.divisor;
	assign shifted = {rem_q[31:0], quo_q[31]};
	assign trial = shifted - {1'b0, dvs_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= 6'd32;
			end else if (busy_q) begin
				cnt_q <= cnt_q - 6'd1;
				if (cnt_q == 6'd1) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			quo_q  <= adiv;
			rem_q  <= '0;
			dvs_q  <= ados;
			negq_q <= req.dividend[31] ^ req.divisor[31];
			negr_q <= req.dividend[31];
			mod_q  <= req.is_mod;
		end else if (busy_q) begin
			if (!trial[32]) begin
				rem_q <= trial;
				quo_q <= {quo_q[30:0], 1'b1};
			end else begin
				rem_q <= shifted;
				quo_q <= {quo_q[30:0], 1'b0};
			end
		end
	end

	always_comb begin
		rsp.done = done_q;
		if (mod_q)
			rsp.value = negr_q ? 32'(-rem_q[31:0]) : rem_q[31:0];
		else
			rsp.value = negq_q ? 32'(-quo_q) : quo_q;
	end

endmodule

@@ design/integer_cpu_execute_unit.sv @@
// Top level of the integer execute unit: sequencer, register file, memory, ALU.
// Steps: accept, decode, memory read (RET, POP and MOV loads only), execute, divider
// (divide or modulo by a divisor other than 0 or -1, 32 divider steps), then output.
// A new word is taken only in the idle state, once the last word has left the sequencer;
// a stalled result holds the sequencer at its last step, the output register parts the sides.
// arst_n clears registers, PC (to 0x20000000) and the halt latch; memory is undefined.
module integer_cpu_execute_unit
	import icx_pkg::*;
#(
	parameter int MEM_WORDS = 4096
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         cfg_we,
	input  logic [31:0]  cfg_wdata,
	input  logic         s_tvalid,
	output logic         s_tready,
	// instruction[31:0], immediate[63:32], port_value[95:64]
	input  logic [95:0]  s_tdata,
	output logic         m_tvalid,
	input  logic         m_tready,
	// next_pc, halted, waiting, fault[2], reg_write, reg_index[4], reg_value[32],
	// mem_write, mem_address[12], mem_value[32]
	output logic [119:0] m_tdata
);

	localparam int AW = $clog2(MEM_WORDS);

	typedef enum logic [5:0] {
		ST_IDLE = 6'b000001,
		ST_DEC  = 6'b000010,
		ST_MEM  = 6'b000100,
		ST_EXE  = 6'b001000,
		ST_DIV  = 6'b010000,
		ST_OUT  = 6'b100000
	} state_t;

	state_t      state_q;
	logic [31:0] regs_q [16];
	logic [31:0] mem_q [MEM_WORDS];
	logic [31:0] pc_q, start_q;
	logic        halt_q, stepped_q;
	logic [31:0] ins_q, imm_q, port_q;
	logic [31:0] d_q, s_q, sp_q, opnd_q, rd_q;
	logic [AW-1:0] raddr_q;
	logic [31:0] npc, alu;
	logic        rw, mw, wait_f;
	logic [1:0]  flt;
	logic [3:0]  ri;
	logic [31:0] rv, mv, ma_full, ma_nxt;
	logic [5:0]  op;
	logic        immf;
	logic [3:0]  dst, src;
	logic [2:0]  mode;
	logic [31:0] immv;
	logic        use_mem;
	logic signed [31:0] sd, so;
	logic [31:0] prod;
	div_req_t    dreq;
	div_rsp_t    drsp;
	logic [119:0] out_q;
	logic        ovalid_q;
	logic        out_go;

	assign op   = ins_q[31:26];
	assign immf = ins_q[25];
	assign dst  = ins_q[24:21];
	assign src  = ins_q[20:17];
	assign mode = ins_q[16:14];
	assign immv = immf ? imm_q : 32'd0;
	assign sd   = signed'(d_q);
	assign so   = signed'(opnd_q);
	assign prod = d_q * opnd_q;

	always_comb begin
		case (op)
			OP_RET, OP_POP: ma_nxt = sp_q;
			OP_MOV: begin
				case (mode)
					3'd2:    ma_nxt = immv;
					3'd3:    ma_nxt = s_q;
					default: ma_nxt = s_q + immv;
				endcase
			end
			default: ma_nxt = '0;
		endcase
		use_mem = !halt_q && (op == OP_RET || op == OP_POP ||
			(op == OP_MOV && (mode == 3'd2 || mode == 3'd3 || mode == 3'd4)));
	end

	assign dreq.start    = (state_q == ST_EXE) && !halt_q && (op == OP_DIV || op == OP_MOD)
		&& opnd_q != 32'd0 && !(opnd_q == 32'hFFFF_FFFF);
	assign dreq.is_mod   = (op == OP_MOD);
	assign dreq.dividend = d_q;
	assign dreq.divisor  = opnd_q;

	icx_divider u_div (.clk(clk), .arst_n(arst_n), .req(dreq), .rsp(drsp));

	always_comb begin
		npc = pc_q + 32'd1 + {31'd0, immf};
		rw = 1'b0; mw = 1'b0; ri = '0; rv = '0; ma_full = '0; mv = '0;
		wait_f = 1'b0; flt = FAULT_NONE; alu = '0;
		if (halt_q) begin
			npc = pc_q;
		end else begin
			case (op)
				OP_HLT: ;
				OP_WAIT: wait_f = 1'b1;
				OP_JMP: npc = immf ? imm_q : d_q;
				OP_CALL: begin
					rw = 1'b1; ri = SP_INDEX; rv = sp_q - 32'd1;
					mw = 1'b1; ma_full = sp_q - 32'd1; mv = npc;
					npc = immf ? imm_q : d_q;
				end
				OP_RET: begin
					npc = rd_q; rw = 1'b1; ri = SP_INDEX; rv = sp_q + 32'd1;
				end
				OP_JT: if (d_q != 0) npc = opnd_q;
				OP_JF: if (d_q == 0) npc = opnd_q;
				OP_IEQ, OP_INE, OP_IGT, OP_IGE, OP_ILT, OP_ILE, OP_MOV, OP_POP, OP_IN,
				OP_CIB, OP_NOT, OP_AND, OP_OR, OP_XOR, OP_BNOT, OP_SHL, OP_ADD, OP_SUB,
				OP_MUL, OP_DIV, OP_MOD: begin
					rw = 1'b1; ri = dst;
					case (op)
						OP_IEQ:  alu = {31'd0, sd == so};
						OP_INE:  alu = {31'd0, sd != so};
						OP_IGT:  alu = {31'd0, sd > so};
						OP_IGE:  alu = {31'd0, sd >= so};
						OP_ILT:  alu = {31'd0, sd < so};
						OP_ILE:  alu = {31'd0, sd <= so};
						OP_POP:  alu = rd_q;
						OP_IN:   alu = port_q;
						OP_CIB:  alu = {31'd0, d_q != 0};
						OP_NOT:  alu = ~d_q;
						OP_AND:  alu = d_q & opnd_q;
						OP_OR:   alu = d_q | opnd_q;
						OP_XOR:  alu = d_q ^ opnd_q;
						OP_BNOT: alu = {31'd0, d_q == 0};
						OP_SHL: begin
							if (so >= 32 || so <= -32) alu = '0;
							else if (!so[31]) alu = d_q << so[4:0];
							else alu = d_q >> 5'(-so[5:0]);
						end
						OP_ADD:  alu = d_q + opnd_q;
						OP_SUB:  alu = d_q - opnd_q;
						OP_MUL:  alu = prod;
						OP_DIV, OP_MOD: begin
							if (opnd_q == 0) begin
								flt = FAULT_DIV0; rw = 1'b0; ri = '0;
							end else if (opnd_q == 32'hFFFF_FFFF)
								alu = (op == OP_DIV) ? 32'(-d_q) : 32'd0;
							else alu = drsp.value;
						end
						OP_MOV: begin
							case (mode)
								3'd0: alu = immv;
								3'd1: alu = s_q;
								3'd2, 3'd3, 3'd4: alu = rd_q;
								default: begin
									rw = 1'b0; ri = '0; mw = 1'b1; mv = s_q;
									ma_full = (mode == 3'd5) ? immv :
										(mode == 3'd6) ? d_q : d_q + immv;
								end
							endcase
						end
						default: alu = '0;
					endcase
					if (rw) rv = alu;
				end
				OP_PUSH: begin
					rw = 1'b1; ri = SP_INDEX; rv = sp_q - 32'd1;
					mw = 1'b1; ma_full = sp_q - 32'd1; mv = d_q;
				end
				default: flt = FAULT_UNSUP;
			endcase
		end
	end

	assign out_go   = (state_q == ST_OUT) && (!ovalid_q || m_tready);
	assign s_tready = (state_q == ST_IDLE);
	assign m_tvalid = ovalid_q;
	assign m_tdata  = out_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			pc_q      <= 32'h2000_0000;
			start_q   <= 32'h2000_0000;
			halt_q    <= 1'b0;
			stepped_q <= 1'b0;
			ovalid_q  <= 1'b0;
			for (int i = 0; i < 16; i++) regs_q[i] <= '0;
		end else begin
			if (cfg_we) begin
				start_q <= cfg_wdata;
				if (!stepped_q) pc_q <= cfg_wdata;
			end
			if (out_go) ovalid_q <= 1'b1;
			else if (m_tready) ovalid_q <= 1'b0;
			unique case (state_q)
				ST_IDLE: if (s_tvalid && s_tready) state_q <= ST_DEC;
				ST_DEC:  state_q <= use_mem ? ST_MEM : ST_EXE;
				ST_MEM:  state_q <= ST_EXE;
				ST_EXE:  state_q <= dreq.start ? ST_DIV : ST_OUT;
				ST_DIV:  if (drsp.done) state_q <= ST_OUT;
				ST_OUT: begin
					if (out_go) begin
						state_q <= ST_IDLE;
						if (!halt_q) begin
							stepped_q <= 1'b1;
							pc_q <= npc;
							if (op == OP_HLT) halt_q <= 1'b1;
							if (op == OP_POP && dst != SP_INDEX)
								regs_q[SP_INDEX] <= sp_q + 32'd1;
							if (rw) regs_q[ri] <= rv;
						end
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			ins_q  <= s_tdata[31:0];
			imm_q  <= s_tdata[63:32];
			port_q <= s_tdata[95:64];
		end
		if (state_q == ST_DEC) begin
			d_q     <= regs_q[dst];
			s_q     <= regs_q[src];
			sp_q    <= regs_q[SP_INDEX];
			opnd_q  <= immf ? imm_q : regs_q[src];
		end
		if (state_q == ST_MEM) rd_q <= mem_q[raddr_q];
		if (out_go) begin
			if (!halt_q && mw) mem_q[ma_full[AW-1:0]] <= mv;
			out_q <= {2'b00, mv, ma_full[11:0] & 12'(MEM_WORDS - 1), mw, rv, ri, rw, flt,
				wait_f, (halt_q || (op == OP_HLT)), npc};
		end
	end

	assign raddr_q = ma_nxt[AW-1:0];

`ifndef SYNTH
	a_hold_out: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata)))
		else $error("result changed while stalled");
	a_out_after: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_OUT) |=> m_tvalid) else $error("result missing");
	a_halt_pc: assert property (@(posedge clk) disable iff (!arst_n)
		($past(halt_q) && halt_q) |-> $stable(pc_q) || $past(cfg_we))
		else $error("pc moved while halted");
`endif

endmodule

@@ sim/integer_cpu_execute_unit_tb.sv @@
// Testbench for the integer execute unit: directed and random instruction streams against a predictor.
module integer_cpu_execute_unit_tb;
	import icx_pkg::*;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int WATCHDOG_LIMIT = 6000;
	localparam int HOLD_CYCLES    = 400;

	typedef struct {
		logic [31:0] next_pc;
		logic        halted;
		logic        waiting;
		logic [1:0]  fault;
		logic        reg_write;
		logic [3:0]  reg_index;
		logic [31:0] reg_value;
		logic        mem_write;
		logic [11:0] mem_address;
		logic [31:0] mem_value;
	} exec_result_t;

	logic         clk;
	logic         arst_n;
	logic         cfg_we;
	logic [31:0]  cfg_wdata;
	logic         s_tvalid;
	logic         s_tready;
	logic [95:0]  s_tdata;
	logic         m_tvalid;
	logic         m_tready;
	logic [119:0] m_tdata;

	// architectural state mirrored by the predictor
	logic [31:0] gpr [16];
	logic [31:0] dmem [4096];
	bit          dmem_valid [4096];
	logic [11:0] stored_addrs [$];
	logic [31:0] pc;
	logic [31:0] start_addr;
	bit          halt_q;
	bit          started;
	exec_result_t cur;

	exec_result_t pending_results [$];
	int  errors;
	int  idle_pct;
	int  stall_pct;
	bit  hold_req;
	int  hold_cnt;
	int  quiet_cycles;

	integer_cpu_execute_unit u_top (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_wdata(cfg_wdata),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

	always begin
		clk = 1'b1;
		#10;
		clk = 1'b0;
		#10;
	end

	function automatic logic [31:0] mem_load(logic [31:0] a);
		return dmem[a[11:0]];
	endfunction

	function automatic void reg_put(logic [3:0] i, logic [31:0] v);
		gpr[i] = v;
		cur.reg_write = 1'b1;
		cur.reg_index = i;
		cur.reg_value = v;
	endfunction

	function automatic void mem_put(logic [31:0] a, logic [31:0] v);
		dmem[a[11:0]] = v;
		if (!dmem_valid[a[11:0]]) begin
			dmem_valid[a[11:0]] = 1'b1;
			stored_addrs.push_back(a[11:0]);
		end
		cur.mem_write   = 1'b1;
		cur.mem_address = a[11:0];
		cur.mem_value   = v;
	endfunction

	function automatic logic [31:0] shift_by(logic [31:0] v, logic [31:0] cnt);
		int signed c;
		c = $signed(cnt);
		if (c >= 32 || c <= -32)
			return 32'd0;
		if (c >= 0)
			return v << c;
		return v >> (-c);
	endfunction

	function automatic exec_result_t execute_word(logic [31:0] ins, logic [31:0] imm_in,
			logic [31:0] port);
		logic        immf;
		logic [31:0] imm, opnd, d, npc, v;
		logic [5:0]  op;
		logic [3:0]  dst, src;
		logic [2:0]  mode;
		immf = ins[25];
		imm  = immf ? imm_in : 32'd0;
		op   = ins[31:26];
		dst  = ins[24:21];
		src  = ins[20:17];
		mode = ins[16:14];
		opnd = immf ? imm : gpr[src];
		d    = gpr[dst];
		npc  = pc + 32'd1 + immf;
		cur  = '{default: '0};
		if (halt_q) begin
			npc = pc;
		end else begin
			started = 1'b1;
			case (op)
				OP_HLT: halt_q = 1'b1;
				OP_WAIT: cur.waiting = 1'b1;
				OP_JMP: npc = immf ? imm : d;
				OP_CALL: begin
					v = gpr[SP_INDEX] - 32'd1;
					reg_put(SP_INDEX, v);
					mem_put(v, npc);
					npc = immf ? imm : d;
				end
				OP_RET: begin
					v = gpr[SP_INDEX];
					npc = mem_load(v);
					reg_put(SP_INDEX, v + 32'd1);
				end
				OP_JT: if (d != 0) npc = opnd;
				OP_JF: if (d == 0) npc = opnd;
				OP_IEQ: reg_put(dst, {31'd0, $signed(d) == $signed(opnd)});
				OP_INE: reg_put(dst, {31'd0, $signed(d) != $signed(opnd)});
				OP_IGT: reg_put(dst, {31'd0, $signed(d) > $signed(opnd)});
				OP_IGE: reg_put(dst, {31'd0, $signed(d) >= $signed(opnd)});
				OP_ILT: reg_put(dst, {31'd0, $signed(d) < $signed(opnd)});
				OP_ILE: reg_put(dst, {31'd0, $signed(d) <= $signed(opnd)});
				OP_MOV: begin
					case (mode)
						3'd0: reg_put(dst, imm);
						3'd1: reg_put(dst, gpr[src]);
						3'd2: reg_put(dst, mem_load(imm));
						3'd3: reg_put(dst, mem_load(gpr[src]));
						3'd4: reg_put(dst, mem_load(gpr[src] + imm));
						3'd5: mem_put(imm, gpr[src]);
						3'd6: mem_put(d, gpr[src]);
						default: mem_put(d + imm, gpr[src]);
					endcase
				end
				OP_PUSH: begin
					v = gpr[SP_INDEX] - 32'd1;
					reg_put(SP_INDEX, v);
					mem_put(v, d);
				end
				OP_POP: begin
					v = gpr[SP_INDEX];
					gpr[SP_INDEX] = v + 32'd1;
					reg_put(dst, mem_load(v));
				end
				OP_IN: reg_put(dst, port);
				OP_CIB: reg_put(dst, {31'd0, d != 0});
				OP_NOT: reg_put(dst, ~d);
				OP_AND: reg_put(dst, d & opnd);
				OP_OR: reg_put(dst, d | opnd);
				OP_XOR: reg_put(dst, d ^ opnd);
				OP_BNOT: reg_put(dst, {31'd0, d == 0});
				OP_SHL: reg_put(dst, shift_by(d, opnd));
				OP_ADD: reg_put(dst, d + opnd);
				OP_SUB: reg_put(dst, d - opnd);
				OP_MUL: reg_put(dst, d * opnd);
				OP_DIV, OP_MOD: begin
					if (opnd == 0)
						cur.fault = FAULT_DIV0;
					else if (d == 32'h8000_0000 && opnd == 32'hFFFF_FFFF)
						reg_put(dst, op == OP_DIV ? 32'h8000_0000 : 32'd0);
					else
						reg_put(dst, op == OP_DIV ? $signed(d) / $signed(opnd)
							: $signed(d) % $signed(opnd));
				end
				default: cur.fault = FAULT_UNSUP;
			endcase
			pc = npc;
		end
		cur.next_pc = npc;
		cur.halted  = halt_q;
		return cur;
	endfunction

	function automatic logic [31:0] encode(logic [5:0] op, logic immf, logic [3:0] dst,
			logic [3:0] src, logic [2:0] mode);
		return {op, immf, dst, src, mode, 14'($urandom)};
	endfunction

	task automatic send_word(logic [31:0] ins, logic [31:0] imm, logic [31:0] port);
		if ($urandom_range(99) < idle_pct) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
			while ($urandom_range(99) < idle_pct)
				@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= {port, imm, ins};
		do
			@(posedge clk);
		while (!s_tready);
		pending_results.push_back(execute_word(ins, imm, port));
	endtask

	task automatic drain();
		s_tvalid <= 1'b0;
		@(posedge clk);
		wait (pending_results.size() == 0);
		repeat (40) @(posedge clk);
	endtask

	task automatic write_start(logic [31:0] v);
		drain();
		cfg_we    <= 1'b1;
		cfg_wdata <= v;
		@(posedge clk);
		start_addr = v;
		if (!started)
			pc = v;
		cfg_we <= 1'b0;
	endtask

	function automatic logic [31:0] pick_value();
		case ($urandom_range(5))
			0: return 32'h8000_0000;
			1: return 32'h7FFF_FFFF;
			2: return 32'hFFFF_FFFF;
			3: return 32'($urandom_range(40)) - 32'd8;
			default: return $urandom;
		endcase
	endfunction

	// keep memory reads on words that have been written
	task automatic random_word();
		logic [31:0] ins, imm, a;
		logic [5:0]  op;
		bit          reads;
		logic [5:0]  ops [26] = '{OP_WAIT, OP_JMP, OP_CALL, OP_RET, OP_JT, OP_JF, OP_IEQ,
			OP_INE, OP_IGT, OP_IGE, OP_ILT, OP_ILE, OP_MOV, OP_MOV, OP_PUSH, OP_POP, OP_IN,
			OP_CIB, OP_NOT, OP_AND, OP_OR, OP_XOR, OP_BNOT, OP_SHL, OP_ADD, OP_DIV};
		logic [5:0]  ops2 [4] = '{OP_SUB, OP_MUL, OP_MOD, OP_MOV};
		if ($urandom_range(9) == 0)
			op = 6'($urandom_range(63, 1));
		else if ($urandom_range(4) == 0)
			op = ops2[$urandom_range(3)];
		else
			op = ops[$urandom_range(25)];
		ins = encode(op, 1'($urandom_range(1)), 4'($urandom), 4'($urandom), 3'($urandom));
		imm = pick_value();
		reads = 1'b0;
		a = 32'd0;
		if (op == OP_RET || op == OP_POP) begin
			reads = 1'b1;
			a = gpr[SP_INDEX];
		end else if (op == OP_MOV) begin
			case (ins[16:14])
				3'd2: begin reads = 1'b1; a = ins[25] ? imm : 32'd0; end
				3'd3: begin reads = 1'b1; a = gpr[ins[20:17]]; end
				3'd4: begin reads = 1'b1; a = gpr[ins[20:17]] + (ins[25] ? imm : 32'd0); end
				default: ;
			endcase
		end
		if (reads && !dmem_valid[a[11:0]]) begin
			if (op == OP_MOV && stored_addrs.size() != 0) begin
				ins[16:14] = 3'd2;
				ins[25]    = 1'b1;
				imm = {20'($urandom), stored_addrs[$urandom_range(stored_addrs.size() - 1)]};
			end else begin
				ins[31:26] = OP_PUSH;
			end
		end
		send_word(ins, imm, $urandom);
	endtask

	task automatic test_start_address();
		write_start(32'hFFFF_FFFF);
		send_word(encode(OP_MOV, 1'b1, 4'd1, 4'd0, 3'd0), 32'h7FFF_FFFF, $urandom);
		write_start(32'd0);
		send_word(encode(OP_MOV, 1'b1, 4'd2, 4'd0, 3'd0), 32'h8000_0000, $urandom);
	endtask

	task automatic test_directed();
		send_word(encode(OP_MOV, 1'b1, 4'd3, 4'd0, 3'd0), 32'hFFFF_FFFF, $urandom);
		send_word(encode(OP_MOV, 1'b0, 4'd4, 4'd0, 3'd0), 32'h1234_5678, $urandom);
		send_word(encode(OP_MOV, 1'b1, 4'd0, 4'd1, 3'd5), 32'd5, $urandom);
		send_word(encode(OP_MOV, 1'b1, 4'd5, 4'd0, 3'd2), 32'hFFFF_F005, $urandom);
		send_word(encode(OP_MOV, 1'b0, 4'd6, 4'd2, 3'd1), $urandom, $urandom);
		send_word(encode(OP_MOV, 1'b0, 4'd4, 4'd3, 3'd6), $urandom, $urandom);
		send_word(encode(OP_MOV, 1'b0, 4'd7, 4'd4, 3'd3), $urandom, $urandom);
		send_word(encode(OP_MOV, 1'b1, 4'd4, 4'd2, 3'd7), 32'd9, $urandom);
		send_word(encode(OP_MOV, 1'b1, 4'd8, 4'd4, 3'd4), 32'd9, $urandom);
		send_word(encode(OP_PUSH, 1'b0, 4'd15, 4'd0, 3'd0), $urandom, $urandom);
		send_word(encode(OP_POP, 1'b0, 4'd15, 4'd0, 3'd0), $urandom, $urandom);
		send_word(encode(OP_CALL, 1'b1, 4'd0, 4'd0, 3'd0), 32'h100, $urandom);
		send_word(encode(OP_RET, 1'b0, 4'd0, 4'd0, 3'd0), $urandom, $urandom);
		send_word(encode(OP_JT, 1'b1, 4'd1, 4'd0, 3'd0), 32'h40, $urandom);
		send_word(encode(OP_JF, 1'b1, 4'd1, 4'd0, 3'd0), 32'h80, $urandom);
		send_word(encode(OP_JMP, 1'b0, 4'd3, 4'd0, 3'd0), $urandom, $urandom);
		send_word(encode(OP_IGT, 1'b0, 4'd1, 4'd2, 3'd0), $urandom, $urandom);
		send_word(encode(OP_ILT, 1'b1, 4'd2, 4'd0, 3'd0), 32'd0, $urandom);
		send_word(encode(OP_IN, 1'b0, 4'd9, 4'd0, 3'd0), $urandom, 32'h8000_0000);
		send_word(encode(OP_MOV, 1'b1, 4'd1, 4'd0, 3'd0), 32'h7FFF_FFFF, $urandom);
		send_word(encode(OP_SHL, 1'b1, 4'd1, 4'd0, 3'd0), 32'd32, $urandom);
		send_word(encode(OP_SHL, 1'b1, 4'd3, 4'd0, 3'd0), 32'hFFFF_FFFF, $urandom);
		send_word(encode(OP_SHL, 1'b1, 4'd3, 4'd0, 3'd0), 32'hFFFF_FFE0, $urandom);
		send_word(encode(OP_MOV, 1'b1, 4'd2, 4'd0, 3'd0), 32'h8000_0000, $urandom);
		send_word(encode(OP_MOD, 1'b1, 4'd2, 4'd0, 3'd0), 32'hFFFF_FFFF, $urandom);
		send_word(encode(OP_MOV, 1'b1, 4'd2, 4'd0, 3'd0), 32'h8000_0000, $urandom);
		send_word(encode(OP_DIV, 1'b1, 4'd2, 4'd0, 3'd0), 32'hFFFF_FFFF, $urandom);
		send_word(encode(OP_DIV, 1'b0, 4'd2, 4'd4, 3'd0), $urandom, $urandom);
		send_word(encode(OP_WAIT, 1'b0, 4'd0, 4'd0, 3'd0), $urandom, $urandom);
		send_word(encode(6'h3F, 1'b1, 4'd0, 4'd0, 3'd0), $urandom, $urandom);
	endtask

	task automatic test_random(int count, int send_idle, int recv_stall, logic [31:0] sa);
		write_start(sa);
		idle_pct  = send_idle;
		stall_pct = recv_stall;
		repeat (count) random_word();
	endtask

	task automatic test_backpressure();
		idle_pct  = 0;
		stall_pct = 0;
		hold_req  = 1'b1;
		repeat (30) random_word();
		drain();
		repeat (20) random_word();
	endtask

	task automatic test_halt();
		write_start(32'h2000_0000);
		send_word(encode(OP_HLT, 1'b1, 4'd0, 4'd0, 3'd0), $urandom, $urandom);
		repeat (5) random_word();
		drain();
	endtask

	always @(posedge clk) begin
		if (hold_req) begin
			hold_req = 1'b0;
			hold_cnt = HOLD_CYCLES;
		end
		if (hold_cnt > 0) begin
			hold_cnt--;
			m_tready <= 1'b0;
		end else begin
			m_tready <= ($urandom_range(99) >= stall_pct);
		end
	end

	always @(posedge clk) begin
		exec_result_t want, got;
		if (arst_n) begin
			if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
				quiet_cycles = 0;
			else
				quiet_cycles++;
			if (quiet_cycles >= WATCHDOG_LIMIT) begin
				$display("integer_cpu_execute_unit verification failed");
				$finish;
			end
			if (m_tvalid && m_tready) begin
				got.next_pc     = m_tdata[31:0];
				got.halted      = m_tdata[32];
				got.waiting     = m_tdata[33];
				got.fault       = m_tdata[35:34];
				got.reg_write   = m_tdata[36];
				got.reg_index   = m_tdata[40:37];
				got.reg_value   = m_tdata[72:41];
				got.mem_write   = m_tdata[73];
				got.mem_address = m_tdata[85:74];
				got.mem_value   = m_tdata[117:86];
				if (pending_results.size() == 0) begin
					$error("unexpected result word %h", m_tdata);
					errors++;
				end else begin
					want = pending_results.pop_front();
					if (got.next_pc !== want.next_pc) begin
						$error("next_pc exp %h got %h", want.next_pc, got.next_pc);
						errors++;
					end
					if (got.halted !== want.halted) begin
						$error("halted exp %0d got %0d", want.halted, got.halted);
						errors++;
					end
					if (got.waiting !== want.waiting) begin
						$error("waiting exp %0d got %0d", want.waiting, got.waiting);
						errors++;
					end
					if (got.fault !== want.fault) begin
						$error("fault exp %0d got %0d", want.fault, got.fault);
						errors++;
					end
					if (got.reg_write !== want.reg_write) begin
						$error("reg_write exp %0d got %0d", want.reg_write, got.reg_write);
						errors++;
					end
					if (got.reg_index !== want.reg_index) begin
						$error("reg_index exp %0d got %0d", want.reg_index, got.reg_index);
						errors++;
					end
					if (got.reg_value !== want.reg_value) begin
						$error("reg_value exp %h got %h", want.reg_value, got.reg_value);
						errors++;
					end
					if (got.mem_write !== want.mem_write) begin
						$error("mem_write exp %0d got %0d", want.mem_write, got.mem_write);
						errors++;
					end
					if (got.mem_address !== want.mem_address) begin
						$error("mem_address exp %h got %h", want.mem_address,
							got.mem_address);
						errors++;
					end
					if (got.mem_value !== want.mem_value) begin
						$error("mem_value exp %h got %h", want.mem_value, got.mem_value);
						errors++;
					end
				end
			end
		end
	end

	initial begin
		arst_n       = 1'b0;
		cfg_we       = 1'b0;
		cfg_wdata    = '0;
		s_tvalid     = 1'b0;
		s_tdata      = '0;
		m_tready     = 1'b0;
		errors       = 0;
		idle_pct     = 0;
		stall_pct    = 0;
		hold_req     = 1'b0;
		hold_cnt     = 0;
		quiet_cycles = 0;
		foreach (gpr[i])
			gpr[i] = '0;
		foreach (dmem[i]) begin
			dmem[i] = '0;
			dmem_valid[i] = 1'b0;
		end
		start_addr = 32'h2000_0000;
		pc         = start_addr;
		halt_q     = 1'b0;
		started    = 1'b0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_start_address();
		test_directed();
		test_random(170, 0, 0, 32'h0000_1000);
		test_random(170, 85, 0, $urandom);
		test_random(170, 0, 85, 32'hFFFF_FFFF);
		test_random(160, 31, 31, 32'd0);
		test_backpressure();
		test_halt();

		if (errors == 0)
			$display("integer_cpu_execute_unit verification clean");
		else
			$display("integer_cpu_execute_unit verification failed");
		$finish;
	end

endmodule
